/* hw/rtl/i2c_bit_level_master_top_defines.svh */
// Assertion macros for the I2C bit-level master checker.
// Depends on nothing; included by the checker file only.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define I2CBLM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cblm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define I2CBLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cblm: next-cycle check failed");

`endif

/* hw/rtl/i2cblm_pkg.sv */
// Shared types and constants for the I2C bit-level master.
// No dependencies; used by the sequencer and the top level.
`timescale 1ns / 1ps

package i2cblm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
   localparam int DELAY_W       = 16;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT      = BIT_IDX_W'(BITS_PER_BYTE - 1);
   localparam logic [DELAY_W-1:0]   HALF_BIT_RESET = 16'd5;

   // Item actions; the idle command code shares the tick code
   typedef enum logic [2:0] {
      ACT_TICK  = 3'd0,
      ACT_START = 3'd1,
      ACT_STOP  = 3'd2,
      ACT_WRITE = 3'd3,
      ACT_READ  = 3'd4,
      ACT_ACK   = 3'd5,
      ACT_NACK  = 3'd6,
      ACT_RXACK = 3'd7
   } action_type;

   // Pin levels driven by the master
   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
   } pins_type;

   // One result item
   typedef struct packed {
      pins_type                   pins;
      logic                       busy;
      logic                       done;
      logic [BITS_PER_BYTE-1:0]   read_data;
      logic                       ack_seen;
      logic                       rejected;
   } rsp_type;

endpackage

/* hw/rtl/i2cblm_seq.sv */
// Bit sequencer of the I2C master: command state, half-bit timer, shifter.
// Depends on i2cblm_pkg.
`timescale 1ns / 1ps

module i2cblm_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [i2cblm_pkg::DELAY_W-1:0]       csr_write_data,
   input  logic                                 step,
   input  i2cblm_pkg::action_type               action,
   input  logic [i2cblm_pkg::BITS_PER_BYTE-1:0] write_data,
   input  logic                                 sda_in,
   output i2cblm_pkg::rsp_type                  result
);

   localparam int BW = i2cblm_pkg::BITS_PER_BYTE;
   localparam int IW = i2cblm_pkg::BIT_IDX_W;
   localparam int DW = i2cblm_pkg::DELAY_W;

   logic [DW-1:0]              half_bit_ticks_ff;
   i2cblm_pkg::action_type     cmd_ff, cmd_in;
   logic [IW-1:0]              bit_idx_ff, bit_idx_in;
   logic                       phase_ff, phase_in;
   logic [DW-1:0]              delay_ff, delay_in;
   logic [BW-1:0]              shift_ff, shift_in;
   i2cblm_pkg::pins_type       pins_ff, pins_in;
   logic                       ack_ff, ack_in;
   logic [BW-1:0]              read_ff, read_in;
   logic                       done;
   logic                       rej;
   logic                       finish;
   logic [DW-1:0]              dlen;

   // Pin setup at the start of each bit or sequence
   function automatic i2cblm_pkg::pins_type bit_setup(i2cblm_pkg::action_type code,
                                                      logic msb,
                                                      i2cblm_pkg::pins_type cur);
      i2cblm_pkg::pins_type p;
      p = cur;
      case (code)
         i2cblm_pkg::ACT_START: begin
            p.drive = 1'b1; p.scl = 1'b1; p.sda = 1'b1;
         end
         i2cblm_pkg::ACT_STOP, i2cblm_pkg::ACT_ACK: begin
            p.drive = 1'b1; p.sda = 1'b0;
         end
         i2cblm_pkg::ACT_NACK: begin
            p.drive = 1'b1; p.sda = 1'b1;
         end
         i2cblm_pkg::ACT_WRITE: begin
            p.drive = 1'b1; p.sda = msb;
         end
         default: begin
            p.drive = 1'b0;
         end
      endcase
      return p;
   endfunction

   // A zero delay setting counts as one tick
   assign dlen = (half_bit_ticks_ff == '0) ? DW'(1) : half_bit_ticks_ff;

   // Next state for one item
   always_comb begin
      cmd_in     = cmd_ff;
      bit_idx_in = bit_idx_ff;
      phase_in   = phase_ff;
      delay_in   = delay_ff;
      shift_in   = shift_ff;
      pins_in    = pins_ff;
      ack_in     = ack_ff;
      read_in    = read_ff;
      done       = 1'b0;
      rej        = 1'b0;
      finish     = 1'b0;

      if (action != i2cblm_pkg::ACT_TICK) begin
         if (cmd_ff != i2cblm_pkg::ACT_TICK) begin
            rej = 1'b1;
         end else begin
            cmd_in     = action;
            bit_idx_in = '0;
            shift_in   = (action == i2cblm_pkg::ACT_WRITE) ? write_data : '0;
            pins_in    = bit_setup(action, shift_in[BW-1], pins_ff);
            phase_in   = 1'b0;
            delay_in   = dlen;
         end
      end else if (cmd_ff != i2cblm_pkg::ACT_TICK) begin
         if (delay_ff > DW'(1)) begin
            delay_in = delay_ff - DW'(1);
         end else if (!phase_ff) begin
            // end of first half-bit
            if (cmd_ff == i2cblm_pkg::ACT_START) pins_in.sda = 1'b0;
            else                                 pins_in.scl = 1'b1;
            phase_in = 1'b1;
            delay_in = dlen;
         end else begin
            // end of second half-bit
            case (cmd_ff)
               i2cblm_pkg::ACT_START: begin
                  pins_in.scl = 1'b0; finish = 1'b1;
               end
               i2cblm_pkg::ACT_STOP: begin
                  pins_in.sda = 1'b1; finish = 1'b1;
               end
               i2cblm_pkg::ACT_RXACK: begin
                  ack_in = !sda_in; pins_in.scl = 1'b0; finish = 1'b1;
               end
               i2cblm_pkg::ACT_WRITE: begin
                  pins_in.scl = 1'b0;
                  shift_in    = {shift_ff[BW-2:0], 1'b0};
               end
               i2cblm_pkg::ACT_READ: begin
                  pins_in.scl = 1'b0;
                  shift_in    = {shift_ff[BW-2:0], sda_in};
               end
               default: begin
                  pins_in.scl = 1'b0; finish = 1'b1;
               end
            endcase

            // byte commands move on to the next bit or end after the last
            if (cmd_ff == i2cblm_pkg::ACT_WRITE || cmd_ff == i2cblm_pkg::ACT_READ) begin
               if (bit_idx_ff != i2cblm_pkg::LAST_BIT) begin
                  bit_idx_in = bit_idx_ff + IW'(1);
                  pins_in    = bit_setup(cmd_ff, shift_in[BW-1], pins_in);
                  phase_in   = 1'b0;
                  delay_in   = dlen;
               end else begin
                  if (cmd_ff == i2cblm_pkg::ACT_READ) read_in = shift_in;
                  finish = 1'b1;
               end
            end

            if (finish) begin
               cmd_in     = i2cblm_pkg::ACT_TICK;
               phase_in   = 1'b0;
               delay_in   = '0;
               bit_idx_in = '0;
               done       = 1'b1;
            end
         end
      end
   end

   // Result seen after this item
   always_comb begin
      result.pins      = pins_in;
      result.busy      = (cmd_in != i2cblm_pkg::ACT_TICK);
      result.done      = done;
      result.read_data = read_in;
      result.ack_seen  = ack_in;
      result.rejected  = rej;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_bit_ticks_ff <= i2cblm_pkg::HALF_BIT_RESET;
         cmd_ff            <= i2cblm_pkg::ACT_TICK;
         bit_idx_ff        <= '0;
         phase_ff          <= 1'b0;
         delay_ff          <= '0;
         shift_ff          <= '0;
         pins_ff           <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
         ack_ff            <= 1'b0;
         read_ff           <= '0;
      end else begin
         if (csr_write_en) half_bit_ticks_ff <= csr_write_data;
         if (step) begin
            cmd_ff     <= cmd_in;
            bit_idx_ff <= bit_idx_in;
            phase_ff   <= phase_in;
            delay_ff   <= delay_in;
            shift_ff   <= shift_in;
            pins_ff    <= pins_in;
            ack_ff     <= ack_in;
            read_ff    <= read_in;
         end
      end
   end

endmodule

/* hw/rtl/i2c_bit_level_master_top.sv */
// I2C bit-level master: an item at the input ports enters the input register at its accepting edge;
// its result is written into the result register when the item moves on, which a stall on the
// result side can delay. Throughput is one item per cycle while the result side does not stall.
// Reset is synchronous, active high: command idle, SCL/SDA high and driven,
// half-bit delay 5 ticks, both registers empty.
`timescale 1ns / 1ps

module i2c_bit_level_master_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write_en,
   input  logic [i2cblm_pkg::DELAY_W-1:0]       csr_write_data,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_action,
   input  logic [i2cblm_pkg::BITS_PER_BYTE-1:0] req_write_data,
   input  logic                                 req_sda_in,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_scl_level,
   output logic                                 rsp_sda_level,
   output logic                                 rsp_sda_drive,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic [i2cblm_pkg::BITS_PER_BYTE-1:0] rsp_read_data,
   output logic                                 rsp_ack_seen,
   output logic                                 rsp_rejected
);

   logic                                 in_valid_ff;
   i2cblm_pkg::action_type               in_action_ff;
   logic [i2cblm_pkg::BITS_PER_BYTE-1:0] in_wdata_ff;
   logic                                 in_sda_ff;
   logic                                 out_valid_ff;
   i2cblm_pkg::rsp_type                  out_ff;
   i2cblm_pkg::rsp_type                  result;
   logic                                 out_free;
   logic                                 step;
   logic                                 in_free;

   // Handshake: the item in the input register moves on when the result slot frees
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign in_free   = !in_valid_ff || step;
   assign req_stall = !in_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_action_ff <= i2cblm_pkg::action_type'(req_action);
         in_wdata_ff  <= req_write_data;
         in_sda_ff    <= req_sda_in;
      end
   end

   i2cblm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .step           (step),
      .action         (in_action_ff),
      .write_data     (in_wdata_ff),
      .sda_in         (in_sda_ff),
      .result         (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) out_ff <= result;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.pins.scl;
   assign rsp_sda_level = out_ff.pins.sda;
   assign rsp_sda_drive = out_ff.pins.drive;
   assign rsp_busy_res  = out_ff.busy;
   assign rsp_done_res  = out_ff.done;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_ack_seen  = out_ff.ack_seen;
   assign rsp_rejected  = out_ff.rejected;

endmodule

/* hw/rtl/i2cblm_checker.sv */
// Port-level checks for the I2C bit-level master, bound to the top level.
// Depends on i2c_bit_level_master_top_defines.svh and the top level.
`timescale 1ns / 1ps
`include "i2c_bit_level_master_top_defines.svh"

module i2cblm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_rejected
);

   // a stalled item keeps its byte
   `I2CBLM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data))

   // a finished sequence leaves the master idle
   `I2CBLM_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)

   // a command is only turned away while a sequence runs
   `I2CBLM_ASSERT_NOW(a_rej_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res && !rsp_done_res)

endmodule

bind i2c_bit_level_master_top i2cblm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_read_data (rsp_read_data),
   .rsp_rejected  (rsp_rejected)
);

/* bench/i2c_bit_level_master_top_tb.sv */
// Self-checking bench for the I2C bit-level master: directed table, then random
// command sequences checked against an in-bench model of the bus sequencer.
// Depends on i2cblm_pkg and i2c_bit_level_master_top.
`timescale 1ns / 1ps

module i2c_bit_level_master_top_tb;

   localparam int IDLE_PCT     = 36;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 900;
   localparam int MAX_PRINTS   = 100;
   localparam int DIR_ROWS     = 24;
   localparam int N_PHASES     = 7;
   localparam logic [15:0] LONG_HALF = 16'h0100;

   // one row of the directed table; a cfg row writes the half-bit register
   typedef struct packed {
      logic                   cfg;
      logic [15:0]            cfg_val;
      i2cblm_pkg::action_type act;
      logic [7:0]             wd;
      logic                   sin;
      logic [7:0]             reps;
      logic                   typed;
      i2cblm_pkg::rsp_type    want;
   } dir_row_type;

   logic                                 clock          = 1'b0;
   logic                                 reset          = 1'b1;
   logic                                 csr_write_en   = 1'b0;
   logic [i2cblm_pkg::DELAY_W-1:0]       csr_write_data = '0;
   logic                                 req_valid      = 1'b0;
   logic                                 req_stall;
   i2cblm_pkg::action_type               req_action     = i2cblm_pkg::ACT_TICK;
   logic [i2cblm_pkg::BITS_PER_BYTE-1:0] req_write_data = '0;
   logic                                 req_sda_in     = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall      = 1'b0;
   logic                                 rsp_scl_level;
   logic                                 rsp_sda_level;
   logic                                 rsp_sda_drive;
   logic                                 rsp_busy_res;
   logic                                 rsp_done_res;
   logic [i2cblm_pkg::BITS_PER_BYTE-1:0] rsp_read_data;
   logic                                 rsp_ack_seen;
   logic                                 rsp_rejected;

   // model of the sequencer and its register
   logic [15:0]            half_ticks = i2cblm_pkg::HALF_BIT_RESET;
   i2cblm_pkg::action_type cur_cmd    = i2cblm_pkg::ACT_TICK;
   logic [3:0]             bit_idx    = '0;
   logic                   phase_q    = 1'b0;
   logic [15:0]            delay_q    = '0;
   logic [7:0]             shift_q    = '0;
   logic                   scl_q      = 1'b1;
   logic                   sda_q      = 1'b1;
   logic                   drive_q    = 1'b1;
   logic                   ack_q      = 1'b0;
   logic [7:0]             rdata_q    = '0;

   i2cblm_pkg::rsp_type pending_states[$];
   int      errors       = 0;
   int      idle_pct     = IDLE_PCT;
   int      items_sent   = 0;
   int      quiet_cycles = 0;
   bit      hold_go      = 1'b0;

   i2c_bit_level_master_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_level  (rsp_scl_level),
      .rsp_sda_level  (rsp_sda_level),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_seen   (rsp_ack_seen),
      .rsp_rejected   (rsp_rejected)
   );

   always #4 clock = ~clock;

   function automatic i2cblm_pkg::rsp_type bus_view(logic scl, logic sda, logic drv,
                                                    logic busy, logic done, logic [7:0] rd,
                                                    logic ack, logic rej);
      i2cblm_pkg::rsp_type r;
      r.pins.scl  = scl;
      r.pins.sda  = sda;
      r.pins.drive = drv;
      r.busy      = busy;
      r.done      = done;
      r.read_data = rd;
      r.ack_seen  = ack;
      r.rejected  = rej;
      return r;
   endfunction

   // zero behaves as a one-tick delay
   function automatic logic [15:0] half_len();
      return (half_ticks == 16'd0) ? 16'd1 : half_ticks;
   endfunction

   // pin setup at the start of a sequence or of the next bit
   function automatic void setup_bit();
      case (cur_cmd)
         i2cblm_pkg::ACT_START: begin
            drive_q = 1'b1; scl_q = 1'b1; sda_q = 1'b1;
         end
         i2cblm_pkg::ACT_STOP, i2cblm_pkg::ACT_ACK: begin
            drive_q = 1'b1; sda_q = 1'b0;
         end
         i2cblm_pkg::ACT_NACK: begin
            drive_q = 1'b1; sda_q = 1'b1;
         end
         i2cblm_pkg::ACT_WRITE: begin
            drive_q = 1'b1; sda_q = shift_q[7];
         end
         default: drive_q = 1'b0;
      endcase
      phase_q = 1'b0;
      delay_q = half_len();
   endfunction

   // advance the bus sequencer by one item and return the pin/status view
   function automatic i2cblm_pkg::rsp_type next_bus_state(i2cblm_pkg::action_type act,
                                                          logic [7:0] wd, logic sin);
      i2cblm_pkg::rsp_type r;
      logic                fin;
      r   = '0;
      fin = 1'b0;
      if (act != i2cblm_pkg::ACT_TICK) begin
         if (cur_cmd != i2cblm_pkg::ACT_TICK) begin
            r.rejected = 1'b1;
         end else begin
            cur_cmd = act;
            bit_idx = '0;
            shift_q = (act == i2cblm_pkg::ACT_WRITE) ? wd : 8'h00;
            setup_bit();
         end
      end else if (cur_cmd != i2cblm_pkg::ACT_TICK) begin
         if (delay_q > 16'd1) begin
            delay_q = delay_q - 16'd1;
         end else if (!phase_q) begin
            // end of first half: start pulls SDA, all others raise SCL
            if (cur_cmd == i2cblm_pkg::ACT_START) sda_q = 1'b0;
            else scl_q = 1'b1;
            phase_q = 1'b1;
            delay_q = half_len();
         end else begin
            case (cur_cmd)
               i2cblm_pkg::ACT_START: begin
                  scl_q = 1'b0; fin = 1'b1;
               end
               i2cblm_pkg::ACT_STOP: begin
                  sda_q = 1'b1; fin = 1'b1;
               end
               i2cblm_pkg::ACT_RXACK: begin
                  ack_q = ~sin; scl_q = 1'b0; fin = 1'b1;
               end
               i2cblm_pkg::ACT_WRITE: begin
                  scl_q = 1'b0; shift_q = {shift_q[6:0], 1'b0};
               end
               i2cblm_pkg::ACT_READ: begin
                  shift_q = {shift_q[6:0], sin}; scl_q = 1'b0;
               end
               default: begin
                  scl_q = 1'b0; fin = 1'b1;
               end
            endcase
            // byte commands: next bit set up on the same tick
            if (!fin) begin
               if (bit_idx + 1 < i2cblm_pkg::BITS_PER_BYTE) begin
                  bit_idx = bit_idx + 4'd1;
                  setup_bit();
               end else begin
                  if (cur_cmd == i2cblm_pkg::ACT_READ) rdata_q = shift_q;
                  fin = 1'b1;
               end
            end
            if (fin) begin
               cur_cmd = i2cblm_pkg::ACT_TICK;
               phase_q = 1'b0;
               delay_q = '0;
               bit_idx = '0;
               r.done  = 1'b1;
            end
         end
      end
      r.pins.scl   = scl_q;
      r.pins.sda   = sda_q;
      r.pins.drive = drive_q;
      r.busy       = (cur_cmd != i2cblm_pkg::ACT_TICK);
      r.read_data  = rdata_q;
      r.ack_seen   = ack_q;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         if (errors <= MAX_PRINTS)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      end
   endfunction

   // offer one item, hold it until taken, then log its expected result
   task automatic send_item(input i2cblm_pkg::action_type act, input logic [7:0] wd,
                            input logic sin, input logic typed,
                            input i2cblm_pkg::rsp_type want);
      i2cblm_pkg::rsp_type got;
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_write_data <= wd;
      req_sda_in     <= sin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act != i2cblm_pkg::ACT_TICK || cur_cmd != i2cblm_pkg::ACT_TICK) items_sent++;
      got = next_bus_state(act, wd, sin);
      pending_states.push_back(typed ? want : got);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_half(input logic [15:0] v);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      half_ticks = v;
   endtask

   // one command run to completion, with stray commands thrown in while busy
   task automatic run_command(input i2cblm_pkg::action_type act);
      logic [2:0] code;
      send_item(act, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), 1'b0, '0);
      while (cur_cmd != i2cblm_pkg::ACT_TICK) begin
         code = ($urandom_range(99, 0) < 4) ? 3'($urandom_range(7, 1)) : 3'd0;
         send_item(i2cblm_pkg::action_type'(code), 8'($urandom_range(255, 0)),
                   1'($urandom_range(1, 0)), 1'b0, '0);
      end
   endtask

   // result side: random stall, plus one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_go = 1'b0;
         end
         rsp_stall <= ($urandom_range(99, 0) < idle_pct);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      i2cblm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_states.size() == 0) begin
            errors++;
            if (errors <= MAX_PRINTS)
               $display("%0t: result with nothing expected", $time);
         end else begin
            want = pending_states.pop_front();
            check_field("scl_level", 8'(want.pins.scl), 8'(rsp_scl_level));
            check_field("sda_level", 8'(want.pins.sda), 8'(rsp_sda_level));
            check_field("sda_drive", 8'(want.pins.drive), 8'(rsp_sda_drive));
            check_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
            check_field("done_res", 8'(want.done), 8'(rsp_done_res));
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("ack_seen", 8'(want.ack_seen), 8'(rsp_ack_seen));
            check_field("rejected", 8'(want.rejected), 8'(rsp_rejected));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows [DIR_ROWS];
      logic [15:0] phase_half [N_PHASES];
      logic [2:0]  code;
      int          i;
      int          r;
      int          target;

      // directed table; the first rows run at the reset delay of 5
      dir_rows[0]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd1,  1'b1,
                       bus_view(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)};
      dir_rows[1]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_START, 8'h00, 1'b0, 8'd1,  1'b1,
                       bus_view(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)};
      dir_rows[2]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_STOP,  8'h00, 1'b0, 8'd1,  1'b1,
                       bus_view(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1)};
      dir_rows[3]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd10, 1'b0, '0};
      dir_rows[4]  = '{1'b1, 16'd1, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd0,  1'b0, '0};
      dir_rows[5]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_STOP,  8'h00, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[6]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd2,  1'b0, '0};
      dir_rows[7]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_ACK,   8'h00, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[8]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd2,  1'b0, '0};
      dir_rows[9]  = '{1'b0, 16'd0, i2cblm_pkg::ACT_NACK,  8'h00, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[10] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd2,  1'b0, '0};
      dir_rows[11] = '{1'b0, 16'd0, i2cblm_pkg::ACT_RXACK, 8'h00, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[12] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd2,  1'b0, '0};
      dir_rows[13] = '{1'b0, 16'd0, i2cblm_pkg::ACT_RXACK, 8'h00, 1'b1, 8'd1,  1'b0, '0};
      dir_rows[14] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b1, 8'd2,  1'b0, '0};
      dir_rows[15] = '{1'b0, 16'd0, i2cblm_pkg::ACT_WRITE, 8'h80, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[16] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd16, 1'b0, '0};
      dir_rows[17] = '{1'b0, 16'd0, i2cblm_pkg::ACT_READ,  8'h00, 1'b1, 8'd1,  1'b0, '0};
      dir_rows[18] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b1, 8'd16, 1'b0, '0};
      dir_rows[19] = '{1'b0, 16'd0, i2cblm_pkg::ACT_READ,  8'hFF, 1'b0, 8'd1,  1'b0, '0};
      dir_rows[20] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'hFF, 1'b0, 8'd16, 1'b0, '0};
      // zero delay behaves as one tick
      dir_rows[21] = '{1'b1, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b0, 8'd0,  1'b0, '0};
      dir_rows[22] = '{1'b0, 16'd0, i2cblm_pkg::ACT_WRITE, 8'hFF, 1'b1, 8'd1,  1'b0, '0};
      dir_rows[23] = '{1'b0, 16'd0, i2cblm_pkg::ACT_TICK,  8'h00, 1'b1, 8'd16, 1'b0, '0};

      // half-bit settings for the random phases; the long one gets a single start
      phase_half[0] = 16'd1;
      phase_half[1] = 16'd2;
      phase_half[2] = 16'd0;
      phase_half[3] = 16'd3;
      phase_half[4] = LONG_HALF;
      phase_half[5] = 16'd5;
      phase_half[6] = 16'd1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].cfg) begin
            write_half(dir_rows[i].cfg_val);
         end else begin
            for (r = 0; r < dir_rows[i].reps; r++)
               send_item(dir_rows[i].act, dir_rows[i].wd, dir_rows[i].sin,
                         dir_rows[i].typed, dir_rows[i].want);
         end
      end

      items_sent = 0;
      for (i = 0; i < N_PHASES; i++) begin
         write_half(phase_half[i]);
         if (phase_half[i] == LONG_HALF) begin
            // long delay: one start, no idling, to keep the run short
            idle_pct = 0;
            run_command(i2cblm_pkg::ACT_START);
            idle_pct = IDLE_PCT;
         end else begin
            idle_pct = (i == 1) ? 0 : IDLE_PCT;
            if (i == 0) hold_go = 1'b1;
            target = items_sent + RANDOM_ITEMS / (N_PHASES - 1);
            while (items_sent < target) begin
               if ($urandom_range(99, 0) < 5) begin
                  send_item(i2cblm_pkg::ACT_TICK, 8'($urandom_range(255, 0)),
                            1'($urandom_range(1, 0)), 1'b0, '0);
               end else begin
                  code = 3'($urandom_range(7, 1));
                  run_command(i2cblm_pkg::action_type'(code));
               end
               // sender pause until the pipe is empty, once in a while
               if ($urandom_range(99, 0) < 3) wait_drained();
            end
            idle_pct = IDLE_PCT;
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
